FILE: rtl/bfvs_pkg.sv
// shared types, constants and helpers of the best-fit victim frame search
package bfvs_pkg;

    // table geometry
    localparam int NUM_ENTRIES = 1024;
    localparam int ADDR_BITS   = 48;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // fixed field widths
    localparam int REQ_INDEX_W   = 10;
    localparam int VICTIM_ADDR_W = 48;
    localparam int OFFSET_W      = 16;
    localparam int SHIFT_W       = 5;

    // page shift limits and reset value
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN   = SHIFT_W'(6);
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX   = SHIFT_W'(16);
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(12);

    // request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;

    // request payload
    typedef struct packed {
        logic                     req_type;
        logic [REQ_INDEX_W-1:0]   entry_index;
        logic [VICTIM_ADDR_W-1:0] victim_address;
        logic [2:0]               flip_bit;
        logic                     flip_sign;
        logic [OFFSET_W-1:0]      target_offset;
    } t_req;

    // response payload
    typedef struct packed {
        logic                   found;
        logic [REQ_INDEX_W-1:0] victim_index;
        logic [OFFSET_W-1:0]    padding;
    } t_rsp;

    // one table entry as kept in memory
    typedef struct packed {
        t_addr      addr;
        logic [2:0] flip_bit;
        logic       flip_sign;
        logic       valid;
        logic       used;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // low-bit mask of the page offset for a given page shift, clamped to range
    function automatic logic [OFFSET_W-1:0] page_mask(input logic [SHIFT_W-1:0] shift);
        logic [SHIFT_W-1:0] eff;
        logic [OFFSET_W:0]  one_hot;
        eff = shift;
        if (shift < PAGE_SHIFT_MIN) begin
            eff = PAGE_SHIFT_MIN;
        end else if (shift > PAGE_SHIFT_MAX) begin
            eff = PAGE_SHIFT_MAX;
        end
        one_hot = (OFFSET_W+1)'(1) << eff;
        return OFFSET_W'(one_hot - (OFFSET_W+1)'(1));
    endfunction

endpackage

FILE: rtl/bfvs_ram.sv
// generic simple dual-port ram with registered read
module bfvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/best_fit_victim_frame_search_top.sv
// top level of the best-fit victim frame search
// Each request is worked alone and the block scans its entry memory once per pass, one entry
// per cycle through the memory's single read port. A load with an in-range index makes one
// pass to learn whether its frame is already used, then the write; other loads are dropped. A
// query makes a search pass, and when a victim fits, a second pass that marks the whole frame
// used. After reset the block clears the memory with req ready low; the config port is always
// ready. The response sits in an output register, so the next request is taken while it waits.
module best_fit_victim_frame_search_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bfvs_pkg::SHIFT_W-1:0]    i_cfg_data,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  bfvs_pkg::t_req                  i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    output bfvs_pkg::t_rsp                  o_rsp
);

    localparam int IDX_W = bfvs_pkg::IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(bfvs_pkg::NUM_ENTRIES - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_LSCAN  = 7'b0000100,
        S_LWRITE = 7'b0001000,
        S_QSCAN  = 7'b0010000,
        S_QMARK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    // control registers
    t_state                         r_state,      n_state;
    logic [bfvs_pkg::SHIFT_W-1:0]   r_page_shift;
    logic [IDX_W-1:0]               r_cnt,        n_cnt;
    logic                           r_issue_done, n_issue_done;
    logic                           r_pipe_vld,   n_pipe_vld;
    logic                           r_used_acc,   n_used_acc;
    logic                           r_have,       n_have;
    logic                           r_rsp_vld,    n_rsp_vld;

    // payload registers
    bfvs_pkg::t_req                 r_req,        n_req;
    logic [IDX_W-1:0]               r_pipe_idx,   n_pipe_idx;
    logic [IDX_W-1:0]               r_best_idx,   n_best_idx;
    logic [bfvs_pkg::OFFSET_W-1:0]  r_best_pad,   n_best_pad;
    bfvs_pkg::t_addr                r_best_addr,  n_best_addr;
    bfvs_pkg::t_rsp                 r_rsp,        n_rsp;

    // memory port signals
    logic                           ram_we;
    logic [IDX_W-1:0]               ram_waddr;
    bfvs_pkg::t_entry               ram_wdata;
    logic [IDX_W-1:0]               ram_raddr;
    logic [bfvs_pkg::ENTRY_W-1:0]   ram_rdata;

    // datapath signals
    logic [bfvs_pkg::OFFSET_W-1:0]  off_mask;
    bfvs_pkg::t_addr                frame_mask;
    bfvs_pkg::t_addr                req_addr;
    bfvs_pkg::t_entry               rd_ent;
    logic [bfvs_pkg::OFFSET_W-1:0]  ent_off;
    logic [bfvs_pkg::OFFSET_W-1:0]  cand_pad;
    logic                           cand;
    logic                           same_frame_req;
    logic                           same_frame_best;
    logic                           cnt_last;
    logic                           pipe_last;
    logic                           issuing;
    logic                           req_fire;
    logic                           load_in_range;
    logic                           rsp_free;

    // entry memory
    bfvs_ram #(
        .WIDTH (bfvs_pkg::ENTRY_W),
        .DEPTH (bfvs_pkg::NUM_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // port outputs
    assign o_cfg_ready = 1'b1;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    // page geometry from the configured shift
    assign off_mask   = bfvs_pkg::page_mask(r_page_shift);
    assign frame_mask = ~bfvs_pkg::t_addr'(off_mask);
    assign req_addr   = bfvs_pkg::t_addr'(r_req.victim_address);

    // entry read back from memory and its comparisons
    assign rd_ent          = bfvs_pkg::t_entry'(ram_rdata);
    assign ent_off         = rd_ent.addr[bfvs_pkg::OFFSET_W-1:0] & off_mask;
    assign cand_pad        = ent_off - r_req.target_offset;
    assign cand            = rd_ent.valid && !rd_ent.used
                             && (rd_ent.flip_bit == r_req.flip_bit)
                             && (rd_ent.flip_sign == r_req.flip_sign)
                             && (ent_off > r_req.target_offset);
    assign same_frame_req  = ((rd_ent.addr ^ req_addr) & frame_mask) == '0;
    assign same_frame_best = ((rd_ent.addr ^ r_best_addr) & frame_mask) == '0;

    // scan control
    assign cnt_last      = (r_cnt == LAST_IDX);
    assign pipe_last     = (r_pipe_idx == LAST_IDX);
    assign issuing       = ((r_state == S_LSCAN) || (r_state == S_QSCAN) || (r_state == S_QMARK))
                           && !r_issue_done;
    assign req_fire      = i_req_valid && o_req_ready;
    assign load_in_range = 32'(i_req.entry_index) < 32'(bfvs_pkg::NUM_ENTRIES);
    assign rsp_free      = !r_rsp_vld || i_rsp_ready;

    // next-state logic
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_issue_done = r_issue_done;
        n_pipe_vld   = issuing;
        n_pipe_idx   = r_cnt;
        n_used_acc   = r_used_acc;
        n_have       = r_have;
        n_rsp_vld    = r_rsp_vld;
        n_req        = r_req;
        n_best_idx   = r_best_idx;
        n_best_pad   = r_best_pad;
        n_best_addr  = r_best_addr;
        n_rsp        = r_rsp;
        ram_we       = 1'b0;
        ram_waddr    = r_pipe_idx;
        ram_wdata    = rd_ent;
        ram_raddr    = r_cnt;

        // read address sweep
        if (issuing) begin
            if (cnt_last) begin
                n_issue_done = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end

        // response taken
        if (r_rsp_vld && i_rsp_ready) begin
            n_rsp_vld = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = '0;
                if (cnt_last) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_req        = i_req;
                    n_cnt        = '0;
                    n_issue_done = 1'b0;
                    n_have       = 1'b0;
                    n_used_acc   = 1'b0;
                    if (i_req.req_type == bfvs_pkg::REQ_QUERY) begin
                        n_state = S_QSCAN;
                    end else if (load_in_range) begin
                        n_state = S_LSCAN;
                    end
                end
            end
            S_LSCAN: begin
                // look for a used entry of the same frame in another slot
                if (r_pipe_vld) begin
                    if ((r_pipe_idx != IDX_W'(r_req.entry_index)) && rd_ent.valid
                        && rd_ent.used && same_frame_req) begin
                        n_used_acc = 1'b1;
                    end
                    if (pipe_last) begin
                        n_state = S_LWRITE;
                    end
                end
            end
            S_LWRITE: begin
                ram_we              = 1'b1;
                ram_waddr           = IDX_W'(r_req.entry_index);
                ram_wdata.addr      = req_addr;
                ram_wdata.flip_bit  = r_req.flip_bit;
                ram_wdata.flip_sign = r_req.flip_sign;
                ram_wdata.valid     = 1'b1;
                ram_wdata.used      = r_used_acc;
                n_state             = S_IDLE;
            end
            S_QSCAN: begin
                // keep the smallest padding, first index on a tie
                if (r_pipe_vld) begin
                    if (cand && (!r_have || (cand_pad < r_best_pad))) begin
                        n_have      = 1'b1;
                        n_best_idx  = r_pipe_idx;
                        n_best_pad  = cand_pad;
                        n_best_addr = rd_ent.addr;
                    end
                    if (pipe_last) begin
                        if (n_have) begin
                            n_state      = S_QMARK;
                            n_cnt        = '0;
                            n_issue_done = 1'b0;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_QMARK: begin
                // mark every valid entry of the chosen frame as used
                if (r_pipe_vld) begin
                    if (rd_ent.valid && same_frame_best) begin
                        ram_we         = 1'b1;
                        ram_wdata.used = 1'b1;
                    end
                    if (pipe_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (rsp_free) begin
                    n_rsp_vld          = 1'b1;
                    n_rsp.found        = r_have;
                    n_rsp.victim_index = r_have ? bfvs_pkg::REQ_INDEX_W'(r_best_idx) : '0;
                    n_rsp.padding      = r_have ? r_best_pad : '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_page_shift <= bfvs_pkg::PAGE_SHIFT_RESET;
            r_cnt        <= '0;
            r_issue_done <= 1'b0;
            r_pipe_vld   <= 1'b0;
            r_used_acc   <= 1'b0;
            r_have       <= 1'b0;
            r_rsp_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_issue_done <= n_issue_done;
            r_pipe_vld   <= n_pipe_vld;
            r_used_acc   <= n_used_acc;
            r_have       <= n_have;
            r_rsp_vld    <= n_rsp_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_page_shift <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_pipe_idx  <= n_pipe_idx;
        r_best_idx  <= n_best_idx;
        r_best_pad  <= n_best_pad;
        r_best_addr <= n_best_addr;
        r_rsp       <= n_rsp;
    end

endmodule

FILE: rtl/bfvs_checker.sv
// port-level checker for the best-fit victim frame search, bound to the top level
module bfvs_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            o_req_ready,
    input  bfvs_pkg::t_req                  i_req,
    input  logic                            o_rsp_valid,
    input  logic                            i_rsp_ready,
    input  bfvs_pkg::t_rsp                  o_rsp
);

    // memory clearing keeps requests out right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready)
        else $error("request ready during memory clearing");

    // a pending response holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    // a miss reports zero index and padding
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.found |-> (o_rsp.victim_index == '0) && (o_rsp.padding == '0))
        else $error("miss response carries nonzero fields");

    // a hit always has positive padding
    a_hit_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.found |-> (o_rsp.padding != '0))
        else $error("hit response with zero padding");

    // a query request keeps the block busy in the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && (i_req.req_type == bfvs_pkg::REQ_QUERY)
        |=> !o_req_ready)
        else $error("request ready right after a query request");

endmodule

bind best_fit_victim_frame_search_top bfvs_checker u_bfvs_checker (.*);
